// File: design/dwg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwg_pkg
// Shared types, constants and the quarter-wave sine table of the DAC
// waveform generator.
// ----------------------------------------------------------------------------
package dwg_pkg;

    localparam int LEVEL_W        = 10;
    localparam int DUTY_W         = 7;
    localparam int PERIOD_W       = 20;
    localparam int WSEL_W         = 2;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = PERIOD_W;
    localparam int IDX_W          = 6;
    localparam int SEG_W          = 2;
    localparam int RAMP_W         = LEVEL_W + 1;
    localparam int SQX_W          = 27;
    localparam int QUARTER_POINTS = 32;
    localparam int TBL_IDX_W      = $clog2(QUARTER_POINTS);
    localparam int SINE_SHIFT     = $clog2(4 * QUARTER_POINTS);
    localparam int RAMP_STEPS_DEF = 32;
    localparam int DUTY_FULL      = 100;

    localparam logic [WSEL_W-1:0]   WAVE_SELECT_RST = 2'd0;
    localparam logic [DUTY_W-1:0]   DUTY_RST        = 7'd50;
    localparam logic [PERIOD_W-1:0] PERIOD_RST      = 20'd20000;
    localparam logic [LEVEL_W-1:0]  FULL_SCALE_RST  = 10'd930;

    typedef enum logic [WSEL_W-1:0] {
        WAVE_SQUARE   = 2'd0,
        WAVE_SAWTOOTH = 2'd1,
        WAVE_SINE     = 2'd2
    } wave_sel_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_WAVE_SELECT = 2'd0,
        CFG_DUTY        = 2'd1,
        CFG_PERIOD      = 2'd2,
        CFG_FULL_SCALE  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        wave_sel_t             wave_sel;
        logic [PERIOD_W-1:0]   period;
        logic [LEVEL_W-1:0]    full_scale;
        logic [SQX_W-1:0]      square_x;   // period * duty, on time times 100
        logic [LEVEL_W-1:0]    ramp_step;
    } dwg_cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               write;
        logic               last;
    } dwg_result_t;

    function automatic logic [LEVEL_W-1:0] quarter_entry(input logic [TBL_IDX_W-1:0] idx);
        logic [LEVEL_W-1:0] v;
        case (idx)
            5'd0:    v = 10'd465;
            5'd1:    v = 10'd489;
            5'd2:    v = 10'd512;
            5'd3:    v = 10'd535;
            5'd4:    v = 10'd559;
            5'd5:    v = 10'd582;
            5'd6:    v = 10'd604;
            5'd7:    v = 10'd626;
            5'd8:    v = 10'd648;
            5'd9:    v = 10'd670;
            5'd10:   v = 10'd691;
            5'd11:   v = 10'd711;
            5'd12:   v = 10'd731;
            5'd13:   v = 10'd750;
            5'd14:   v = 10'd768;
            5'd15:   v = 10'd785;
            5'd16:   v = 10'd802;
            5'd17:   v = 10'd818;
            5'd18:   v = 10'd833;
            5'd19:   v = 10'd847;
            5'd20:   v = 10'd860;
            5'd21:   v = 10'd872;
            5'd22:   v = 10'd882;
            5'd23:   v = 10'd892;
            5'd24:   v = 10'd901;
            5'd25:   v = 10'd909;
            5'd26:   v = 10'd915;
            5'd27:   v = 10'd920;
            5'd28:   v = 10'd925;
            5'd29:   v = 10'd928;
            5'd30:   v = 10'd929;
            default: v = 10'd930;
        endcase
        return v;
    endfunction

endpackage

// File: design/dwg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwg_core
// Waveform position state and the per-tick level, write and cycle end logic.
// ----------------------------------------------------------------------------
module dwg_core #(
    parameter int RAMP_STEPS = dwg_pkg::RAMP_STEPS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                tick_en,
    input  logic                restart,
    input  dwg_pkg::dwg_cfg_t   cfg,
    output dwg_pkg::dwg_result_t result
);

    localparam int HC_W  = dwg_pkg::PERIOD_W;
    localparam int SAW_W = HC_W + 1 + $clog2(RAMP_STEPS + 1);
    localparam logic [dwg_pkg::IDX_W-1:0] LAST_IDX = dwg_pkg::IDX_W'(dwg_pkg::QUARTER_POINTS - 1);

    logic [HC_W-1:0]              hold_counter_reg, hold_counter_next;
    logic [dwg_pkg::IDX_W-1:0]    sample_index_reg, sample_index_next;
    logic [dwg_pkg::SEG_W-1:0]    quarter_segment_reg, quarter_segment_next;
    logic [dwg_pkg::RAMP_W-1:0]   ramp_level_reg, ramp_level_next;
    logic                         square_low_reg, square_low_next;
    logic [dwg_pkg::LEVEL_W-1:0]  current_level_reg, current_level_next;

    logic [HC_W-1:0]              hc_cur, hc_wrap, hc_diff;
    logic [HC_W:0]                hc_p1;
    logic [dwg_pkg::IDX_W-1:0]    idx_cur;
    logic [dwg_pkg::SEG_W-1:0]    seg_cur;
    logic [dwg_pkg::RAMP_W-1:0]   ramp_cur, ramp_sum;
    logic                         low_cur;
    logic                         on_done, off_done, saw_done, sine_done;
    logic [dwg_pkg::LEVEL_W-1:0]  entry;
    logic                         write, last;

    always_comb begin
        hc_cur   = restart ? '0 : hold_counter_reg;
        idx_cur  = restart ? '0 : sample_index_reg;
        seg_cur  = restart ? '0 : quarter_segment_reg;
        ramp_cur = restart ? '0 : ramp_level_reg;
        low_cur  = restart ? 1'b0 : square_low_reg;

        hc_wrap = hc_cur + 1'b1;
        hc_p1   = {1'b0, hc_wrap} + 1'b1;
        hc_diff = cfg.period - hc_wrap;

        // hold reached without dividing: compare against the scaled product
        on_done  = (hc_wrap == '0)
                || ((dwg_pkg::SQX_W'(hc_p1) * dwg_pkg::SQX_W'(100)) > cfg.square_x);
        off_done = (hc_wrap == '0) || (hc_wrap >= cfg.period)
                || (cfg.square_x >= (dwg_pkg::SQX_W'(hc_diff) * dwg_pkg::SQX_W'(100)));
        saw_done = (hc_wrap == '0)
                || ((SAW_W'(hc_p1) * SAW_W'(RAMP_STEPS)) > SAW_W'(cfg.period));
        sine_done = (hc_wrap == '0) || (hc_wrap >= (cfg.period >> dwg_pkg::SINE_SHIFT));

        ramp_sum = ramp_cur + dwg_pkg::RAMP_W'(cfg.ramp_step);
        entry    = dwg_pkg::quarter_entry(idx_cur[dwg_pkg::TBL_IDX_W-1:0]);

        hold_counter_next    = hc_cur;
        sample_index_next    = idx_cur;
        quarter_segment_next = seg_cur;
        ramp_level_next      = ramp_cur;
        square_low_next      = low_cur;
        current_level_next   = current_level_reg;
        write                = 1'b0;
        last                 = 1'b0;

        case (cfg.wave_sel)
            dwg_pkg::WAVE_SQUARE: begin
                if (hc_cur == '0) begin
                    current_level_next = low_cur ? '0 : cfg.full_scale;
                    write              = 1'b1;
                end
                if (low_cur ? off_done : on_done) begin
                    hold_counter_next = '0;
                    square_low_next   = ~low_cur;
                    last              = low_cur;
                end else begin
                    hold_counter_next = hc_wrap;
                end
            end
            dwg_pkg::WAVE_SAWTOOTH: begin
                if (hc_cur == '0) begin
                    current_level_next = (ramp_cur > {1'b0, cfg.full_scale})
                                       ? cfg.full_scale : ramp_cur[dwg_pkg::LEVEL_W-1:0];
                    write              = 1'b1;
                end
                if (saw_done) begin
                    hold_counter_next = '0;
                    if (ramp_sum >= {1'b0, cfg.full_scale}) begin
                        ramp_level_next = '0;
                        last            = 1'b1;
                    end else begin
                        ramp_level_next = ramp_sum;
                    end
                end else begin
                    hold_counter_next = hc_wrap;
                end
            end
            dwg_pkg::WAVE_SINE: begin
                if (hc_cur == '0) begin
                    if (seg_cur < 2'd2) begin
                        current_level_next = entry;
                    end else begin
                        current_level_next = (cfg.full_scale > entry)
                                           ? cfg.full_scale - entry : '0;
                    end
                    write = 1'b1;
                end
                if (sine_done) begin
                    hold_counter_next = '0;
                    case (seg_cur)
                        2'd0, 2'd2: begin
                            if (idx_cur >= LAST_IDX) begin
                                quarter_segment_next = seg_cur + 1'b1;
                                sample_index_next    = LAST_IDX - 1'b1;
                            end else begin
                                sample_index_next = idx_cur + 1'b1;
                            end
                        end
                        2'd1: begin
                            if (idx_cur == '0) begin
                                quarter_segment_next = 2'd2;
                                sample_index_next    = dwg_pkg::IDX_W'(1);
                            end else begin
                                sample_index_next = idx_cur - 1'b1;
                            end
                        end
                        default: begin
                            if (idx_cur <= dwg_pkg::IDX_W'(1)) begin
                                quarter_segment_next = '0;
                                sample_index_next    = '0;
                                last                 = 1'b1;
                            end else begin
                                sample_index_next = idx_cur - 1'b1;
                            end
                        end
                    endcase
                end else begin
                    hold_counter_next = hc_wrap;
                end
            end
            default: begin
                // unused selector: level held, nothing written
            end
        endcase

        result.level = current_level_next;
        result.write = write;
        result.last  = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_counter_reg    <= '0;
            sample_index_reg    <= '0;
            quarter_segment_reg <= '0;
            ramp_level_reg      <= '0;
            square_low_reg      <= 1'b0;
            current_level_reg   <= '0;
        end else if (tick_en) begin
            hold_counter_reg    <= hold_counter_next;
            sample_index_reg    <= sample_index_next;
            quarter_segment_reg <= quarter_segment_next;
            ramp_level_reg      <= ramp_level_next;
            square_low_reg      <= square_low_next;
            current_level_reg   <= current_level_next;
        end
    end

endmodule

// File: design/dac_waveform_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_waveform_generator
// Tick driven square, sawtooth and quarter-wave sine generator for a 10-bit
// DAC, with a plain register write port for its settings.
//
//   channel | direction | tdata                  | tuser       | tlast
//   s_axis  | in        | [0] restart            | -           | -
//   m_axis  | out       | [9:0] dac_level        | level_write | cycle_end
//   cfg     | in        | write enable, index, data (no read-back)
//
// One request per cycle sustained while results are taken; a result is offered
// once its request has passed an input register and a result register.
// The input side keeps taking requests while a result waits, until the
// input register is also full. Reset is synchronous, active low.
// Derived settings (square on time, ramp step) are registered from the
// setting registers after a configuration write.
// ----------------------------------------------------------------------------
module dac_waveform_generator #(
    parameter int RAMP_STEPS = dwg_pkg::RAMP_STEPS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [0] restart
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,   // [9:0] dac_level
    output logic                               m_axis_tuser,   // level_write
    output logic                               m_axis_tlast,   // cycle_end
    input  logic                               cfg_wr_en,
    input  logic [dwg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [dwg_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int STEP_SH = dwg_pkg::LEVEL_W + $clog2(RAMP_STEPS);
    localparam int STEP_M  = ((1 << STEP_SH) + RAMP_STEPS - 1) / RAMP_STEPS;
    localparam int STEP_PW = dwg_pkg::LEVEL_W + STEP_SH;

    logic [dwg_pkg::WSEL_W-1:0]   wave_select_reg;
    logic [dwg_pkg::DUTY_W-1:0]   duty_reg;
    logic [dwg_pkg::PERIOD_W-1:0] period_reg;
    logic [dwg_pkg::LEVEL_W-1:0]  full_scale_reg;
    logic [dwg_pkg::SQX_W-1:0]    square_x_reg, square_x_next;
    logic [dwg_pkg::LEVEL_W-1:0]  ramp_step_reg, ramp_step_next;
    logic [dwg_pkg::DUTY_W-1:0]   duty_eff;
    logic [STEP_PW-1:0]           step_prod;

    logic                         in_valid_reg, in_valid_next;
    logic                         in_restart_reg;
    logic                         out_valid_reg, out_valid_next;
    dwg_pkg::dwg_result_t         out_reg;
    dwg_pkg::dwg_result_t         core_result;
    dwg_pkg::dwg_cfg_t            cfg;
    logic                         advance;
    logic                         s_accept;
    logic                         m_accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_select_reg <= dwg_pkg::WAVE_SELECT_RST;
            duty_reg        <= dwg_pkg::DUTY_RST;
            period_reg      <= dwg_pkg::PERIOD_RST;
            full_scale_reg  <= dwg_pkg::FULL_SCALE_RST;
        end else if (cfg_wr_en) begin
            case (dwg_pkg::cfg_index_t'(cfg_addr))
                dwg_pkg::CFG_WAVE_SELECT: wave_select_reg <= cfg_wr_data[dwg_pkg::WSEL_W-1:0];
                dwg_pkg::CFG_DUTY:        duty_reg        <= cfg_wr_data[dwg_pkg::DUTY_W-1:0];
                dwg_pkg::CFG_PERIOD:      period_reg      <= cfg_wr_data;
                dwg_pkg::CFG_FULL_SCALE:  full_scale_reg  <= cfg_wr_data[dwg_pkg::LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ramp step is full_scale over the step count, by reciprocal multiply
    always_comb begin
        duty_eff = (duty_reg > dwg_pkg::DUTY_W'(dwg_pkg::DUTY_FULL))
                 ? dwg_pkg::DUTY_W'(dwg_pkg::DUTY_FULL) : duty_reg;
        square_x_next = dwg_pkg::SQX_W'(period_reg) * dwg_pkg::SQX_W'(duty_eff);
        step_prod = STEP_PW'(full_scale_reg) * STEP_PW'(STEP_M);
        ramp_step_next = dwg_pkg::LEVEL_W'(step_prod >> STEP_SH);
        if (ramp_step_next == '0) begin
            ramp_step_next = dwg_pkg::LEVEL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        square_x_reg  <= square_x_next;
        ramp_step_reg <= ramp_step_next;
    end

    always_comb begin
        cfg.wave_sel   = dwg_pkg::wave_sel_t'(wave_select_reg);
        cfg.period     = period_reg;
        cfg.full_scale = full_scale_reg;
        cfg.square_x   = square_x_reg;
        cfg.ramp_step  = ramp_step_reg;
    end

    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign m_accept      = m_axis_tvalid & m_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_accept) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_restart_reg <= s_axis_tdata[0];
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    dwg_core #(
        .RAMP_STEPS (RAMP_STEPS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (advance),
        .restart (in_restart_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16 - dwg_pkg::LEVEL_W){1'b0}}, out_reg.level};
    assign m_axis_tuser  = out_reg.write;
    assign m_axis_tlast  = out_reg.last;

    // a held request always moves into an empty result register
    a_fill_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("held request not moved to result register");

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a full pipeline");

    a_request_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(in_valid_reg) |-> out_valid_reg)
        else $error("request left input register without a result");

endmodule

// File: tb/sv/dwg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwg_checker
// Watches the tick and result streams and the register write port of the DAC
// waveform generator. It keeps its own copy of the settings and position
// state, predicts each result and compares it with the DUT output.
// ----------------------------------------------------------------------------
module dwg_checker
    import dwg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [0] restart
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [15:0]           m_axis_tdata,   // [9:0] dac_level
    input  logic                  m_axis_tuser,   // level_write
    input  logic                  m_axis_tlast,   // cycle_end
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output int                    mismatches,
    output int                    outstanding,
    output int                    results_checked,
    output int                    cycle_ends
);

    // quarter-wave sine entries, entry i at bits [10*i +: 10]
    localparam logic [QUARTER_POINTS*LEVEL_W-1:0] SINE_QUARTER = {
        10'd930, 10'd929, 10'd928, 10'd925, 10'd920, 10'd915, 10'd909, 10'd901,
        10'd892, 10'd882, 10'd872, 10'd860, 10'd847, 10'd833, 10'd818, 10'd802,
        10'd785, 10'd768, 10'd750, 10'd731, 10'd711, 10'd691, 10'd670, 10'd648,
        10'd626, 10'd604, 10'd582, 10'd559, 10'd535, 10'd512, 10'd489, 10'd465
    };

    logic [WSEL_W-1:0]   wave_cfg;
    logic [DUTY_W-1:0]   duty_cfg;
    logic [PERIOD_W-1:0] period_cfg;
    logic [LEVEL_W-1:0]  peak_cfg;

    logic [PERIOD_W-1:0] hold_cnt;
    logic [IDX_W-1:0]    sine_idx;
    logic [SEG_W-1:0]    sine_seg;
    logic [RAMP_W-1:0]   ramp_lvl;
    logic                sq_low;
    logic [LEVEL_W-1:0]  dac_lvl;

    dwg_result_t predicted_ticks[$];
    dwg_result_t nxt;
    dwg_result_t want;

    task automatic play_tick(input logic restart, output dwg_result_t r);
        logic [DUTY_W-1:0]   duty;
        logic [SQX_W-1:0]    on_x;
        logic [PERIOD_W-1:0] on_t;
        logic [PERIOD_W-1:0] hold;
        logic [RAMP_W-1:0]   step;
        logic [LEVEL_W-1:0]  entry;
        logic                done;
        r    = '0;
        hold = '0;
        step = '0;
        if (restart) begin
            hold_cnt = '0;
            sine_idx = '0;
            sine_seg = '0;
            ramp_lvl = '0;
            sq_low   = 1'b0;
        end
        case (wave_cfg)
            WAVE_SQUARE: begin
                duty = (duty_cfg > DUTY_FULL) ? DUTY_W'(DUTY_FULL) : duty_cfg;
                on_x = period_cfg * duty;
                on_t = PERIOD_W'(on_x / DUTY_FULL);
                if (hold_cnt == 0) begin
                    dac_lvl = sq_low ? '0 : peak_cfg;
                    r.write = 1'b1;
                end
                hold = sq_low ? period_cfg - on_t : on_t;
            end
            WAVE_SAWTOOTH: begin
                step = peak_cfg / RAMP_STEPS_DEF;
                if (step == 0) step = 1;
                if (hold_cnt == 0) begin
                    dac_lvl = (ramp_lvl > peak_cfg) ? peak_cfg : ramp_lvl[LEVEL_W-1:0];
                    r.write = 1'b1;
                end
                hold = period_cfg / RAMP_STEPS_DEF;
            end
            WAVE_SINE: begin
                if (hold_cnt == 0) begin
                    entry = SINE_QUARTER[LEVEL_W*sine_idx[TBL_IDX_W-1:0] +: LEVEL_W];
                    if (sine_seg < 2)
                        dac_lvl = entry;
                    else
                        dac_lvl = (peak_cfg > entry) ? peak_cfg - entry : '0;
                    r.write = 1'b1;
                end
                hold = period_cfg / (4 * QUARTER_POINTS);
            end
            default: ;
        endcase
        if (wave_cfg <= WAVE_SINE) begin
            if (hold == 0) hold = 1;
            hold_cnt = hold_cnt + 1'b1;
            done = (hold_cnt >= hold) || (hold_cnt == 0);
            if (done) begin
                hold_cnt = '0;
                case (wave_cfg)
                    WAVE_SQUARE: begin
                        r.last = sq_low;
                        sq_low = ~sq_low;
                    end
                    WAVE_SAWTOOTH: begin
                        ramp_lvl = ramp_lvl + step;
                        if (ramp_lvl >= peak_cfg) begin
                            ramp_lvl = '0;
                            r.last   = 1'b1;
                        end
                    end
                    default: begin
                        // forward, backward, mirrored forward, mirrored backward
                        case (sine_seg)
                            2'd0, 2'd2: begin
                                if (sine_idx >= QUARTER_POINTS - 1) begin
                                    sine_seg = sine_seg + 1'b1;
                                    sine_idx = QUARTER_POINTS - 2;
                                end else begin
                                    sine_idx = sine_idx + 1'b1;
                                end
                            end
                            2'd1: begin
                                if (sine_idx == 0) begin
                                    sine_seg = 2'd2;
                                    sine_idx = 1;
                                end else begin
                                    sine_idx = sine_idx - 1'b1;
                                end
                            end
                            default: begin
                                if (sine_idx <= 1) begin
                                    sine_seg = 2'd0;
                                    sine_idx = '0;
                                    r.last   = 1'b1;
                                end else begin
                                    sine_idx = sine_idx - 1'b1;
                                end
                            end
                        endcase
                    end
                endcase
            end
        end
        r.level = dac_lvl;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            wave_cfg   = WAVE_SELECT_RST;
            duty_cfg   = DUTY_RST;
            period_cfg = PERIOD_RST;
            peak_cfg   = FULL_SCALE_RST;
            hold_cnt   = '0;
            sine_idx   = '0;
            sine_seg   = '0;
            ramp_lvl   = '0;
            sq_low     = 1'b0;
            dac_lvl    = '0;
            predicted_ticks.delete();
            mismatches      = 0;
            results_checked = 0;
            cycle_ends      = 0;
            outstanding    <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_WAVE_SELECT: wave_cfg   = cfg_wr_data[WSEL_W-1:0];
                    CFG_DUTY:        duty_cfg   = cfg_wr_data[DUTY_W-1:0];
                    CFG_PERIOD:      period_cfg = cfg_wr_data[PERIOD_W-1:0];
                    default:         peak_cfg   = cfg_wr_data[LEVEL_W-1:0];
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_ticks.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request pending, tdata %h", $time,
                             m_axis_tdata);
                end else begin
                    want = predicted_ticks.pop_front();
                    results_checked++;
                    if (want.last) cycle_ends++;
                    if (m_axis_tdata !== {{(16-LEVEL_W){1'b0}}, want.level}) begin
                        mismatches++;
                        $display("%0t: dac_level expected %h got %h", $time,
                                 {{(16-LEVEL_W){1'b0}}, want.level}, m_axis_tdata);
                    end
                    if (m_axis_tuser !== want.write) begin
                        mismatches++;
                        $display("%0t: level_write expected %b got %b", $time,
                                 want.write, m_axis_tuser);
                    end
                    if (m_axis_tlast !== want.last) begin
                        mismatches++;
                        $display("%0t: cycle_end expected %b got %b", $time,
                                 want.last, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                play_tick(s_axis_tdata[0], nxt);
                predicted_ticks.push_back(nxt);
            end
            outstanding <= predicted_ticks.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the DAC waveform generator. Drives tick and restart
// requests under a series of register settings with random gaps on both
// streams; the checker beside the DUT predicts and compares every result.
// ----------------------------------------------------------------------------
module tb
    import dwg_pkg::*;
;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int TICK_TARGET     = 820;
    localparam int FILL_PHASE      = 3;
    localparam logic [WSEL_W-1:0] WAVE_UNUSED = 2'd3;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;     // [0] restart
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;           // [9:0] dac_level
    logic                  m_axis_tuser;           // level_write
    logic                  m_axis_tlast;           // cycle_end
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = CFG_WAVE_SELECT;
    logic [CFG_DATA_W-1:0] cfg_wr_data   = '0;

    logic hold_off_req  = 1'b0;
    logic hold_off_done = 1'b0;
    int   rx_idle = 0;
    int   rx_calm = 0;
    int   rx_pick;
    int   tx_calm = 0;
    int   cycle_count = 0;
    int   ticks_sent = 0;
    int   settings_run = 0;

    int mismatches;
    int outstanding;
    int results_checked;
    int cycle_ends;

    logic [WSEL_W-1:0]   rnd_wave;
    logic [DUTY_W-1:0]   rnd_duty;
    logic [PERIOD_W-1:0] rnd_period;
    logic [LEVEL_W-1:0]  rnd_peak;
    int                  rnd_len;
    int                  pick;

    always #5 aclk = ~aclk;

    dac_waveform_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    dwg_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .cycle_ends      (cycle_ends)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count,
                     outstanding);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side back-pressure, with one long hold-off while the input fills
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_idle       <= 0;
            rx_calm       <= 0;
            hold_off_done <= 1'b0;
        end else if (hold_off_req && !hold_off_done) begin
            hold_off_done <= 1'b1;
            rx_idle       <= HOLD_OFF_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_idle > 0) begin
            rx_idle       <= rx_idle - 1;
            m_axis_tready <= (rx_idle == 1);
        end else if (rx_calm > 0) begin
            rx_calm       <= rx_calm - 1;
            m_axis_tready <= 1'b1;
        end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 3) begin
                rx_calm       <= $urandom_range(20, 100);
                m_axis_tready <= 1'b1;
            end else if (rx_pick < 30) begin
                rx_idle       <= $urandom_range(1, 3);
                m_axis_tready <= 1'b0;
            end else if (rx_pick < 36) begin
                rx_idle       <= $urandom_range(4, 15);
                m_axis_tready <= 1'b0;
            end else if (rx_pick < 38) begin
                rx_idle       <= $urandom_range(20, 50);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_tick(input logic restart, input bit burst);
        int gap;
        int r;
        gap = 0;
        if (!burst) begin
            if (tx_calm > 0) begin
                tx_calm--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    tx_calm = $urandom_range(20, 80);
                else if (r < 33)
                    gap = $urandom_range(1, 3);
                else if (r < 40)
                    gap = $urandom_range(4, 12);
                else if (r < 42)
                    gap = $urandom_range(20, 60);
            end
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do @(posedge aclk); while (!s_axis_tready);
        ticks_sent++;
    endtask

    // settings are only written once every result of the previous run is back
    task automatic run_phase(input logic [WSEL_W-1:0] wave, input logic [DUTY_W-1:0] duty,
                             input logic [PERIOD_W-1:0] period, input logic [LEVEL_W-1:0] peak,
                             input int n_ticks, input bit first_restart, input bit burst);
        do @(posedge aclk); while (outstanding != 0);
        repeat (2) @(posedge aclk);
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= cfg_index_t'(i);
            case (cfg_index_t'(i))
                CFG_WAVE_SELECT: cfg_wr_data <= CFG_DATA_W'(wave);
                CFG_DUTY:        cfg_wr_data <= CFG_DATA_W'(duty);
                CFG_PERIOD:      cfg_wr_data <= period;
                default:         cfg_wr_data <= CFG_DATA_W'(peak);
            endcase
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        repeat (2) @(posedge aclk);
        if (burst) hold_off_req <= 1'b1;
        for (int k = 0; k < n_ticks; k++)
            send_tick((k == 0) ? first_restart : ($urandom_range(0, 99) < 3), burst);
        s_axis_tvalid <= 1'b0;
        settings_run++;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings first
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        s_axis_tvalid <= 1'b0;

        run_phase(WAVE_SQUARE,   7'd0,   20'd2,       10'd1023, 4, 1'b1, 1'b0);
        run_phase(WAVE_SQUARE,   7'd127, 20'd1,       10'd1023, 3, 1'b1, 1'b0);
        run_phase(WAVE_SAWTOOTH, 7'd50,  20'd0,       10'd0,    3, 1'b1, 1'b0);
        run_phase(WAVE_SAWTOOTH, 7'd50,  20'd64,      10'd20,   4, 1'b1, 1'b0);
        run_phase(WAVE_SINE,     7'd50,  20'd0,       10'd0,    4, 1'b1, 1'b0);
        run_phase(WAVE_UNUSED,   7'd50,  20'hFFFFF,   10'd1023, 3, 1'b0, 1'b0);
        run_phase(WAVE_SINE,     7'd100, 20'hFFFFF,   10'd1023, 2, 1'b1, 1'b0);

        while (ticks_sent < TICK_TARGET) begin
            pick = $urandom_range(0, 99);
            rnd_wave = (pick < 30) ? WAVE_SQUARE : (pick < 60) ? WAVE_SAWTOOTH :
                       (pick < 95) ? WAVE_SINE : WAVE_UNUSED;
            pick = $urandom_range(0, 99);
            rnd_duty = (pick < 10) ? 7'd0 : (pick < 20) ? 7'd100 :
                       (pick < 30) ? DUTY_W'($urandom_range(101, 127)) :
                       DUTY_W'($urandom_range(0, 100));
            pick = $urandom_range(0, 99);
            rnd_period = (pick < 45) ? PERIOD_W'($urandom_range(0, 40)) :
                         (pick < 70) ? PERIOD_W'($urandom_range(41, 400)) :
                         (pick < 85) ? PERIOD_W'($urandom_range(0, 4095)) :
                         (pick < 95) ? PERIOD_W'($urandom) : 20'hFFFFF;
            pick = $urandom_range(0, 99);
            rnd_peak = (pick < 10) ? 10'd0 : (pick < 20) ? 10'd1023 :
                       (pick < 35) ? LEVEL_W'($urandom_range(1, 40)) : LEVEL_W'($urandom);
            if (rnd_wave == WAVE_SINE && rnd_period < 256 && $urandom_range(0, 1) == 1)
                rnd_len = $urandom_range(130, 260);
            else
                rnd_len = $urandom_range(15, 70);
            if (settings_run == FILL_PHASE + 7)
                run_phase(rnd_wave, rnd_duty, rnd_period, rnd_peak, 60, 1'b0, 1'b1);
            else
                run_phase(rnd_wave, rnd_duty, rnd_period, rnd_peak, rnd_len,
                          $urandom_range(0, 9) < 3, 1'b0);
        end

        do @(posedge aclk); while (outstanding != 0);
        repeat (10) @(posedge aclk);

        $display("%0d tick requests over %0d register settings, %0d results, %0d cycle ends",
                 ticks_sent, settings_run, results_checked, cycle_ends);
        $display("waveforms, unused selector, restarts, random gaps and a %0d-cycle hold-off",
                 HOLD_OFF_CYCLES);
        if (outstanding != 0)
            $display("%0d expected results never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
